### src/akf_pkg.sv
package akf_pkg;

   // Fixed field widths
   localparam int MEAS_W     = 32;
   localparam int TIME_W     = 48;
   localparam int VAR_W      = 32;
   localparam int STATUS_W   = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Default fraction width of the Q format
   localparam int FRAC_BITS_DEF = 16;

   // Register reset values
   localparam logic [31:0] PROCESS_NOISE_RST = 32'd13107;
   localparam logic [31:0] MEASURE_NOISE_RST = 32'd1638;
   localparam logic [31:0] VARIANCE_RST      = 32'd3277;

   // Register index, taken from address bit 2
   localparam logic REG_PROCESS_NOISE = 1'b0;
   localparam logic REG_MEASURE_NOISE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_LOAD   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UPDATE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

   // Arithmetic constants
   localparam logic [31:0] MASK32     = 32'hFFFF_FFFF;
   localparam logic [31:0] GATE_SCALE = 32'd100000;
   localparam logic [31:0] USEC_DIV   = 32'd1000000;
   localparam logic [31:0] USEC_DIV2  = 32'd2000000;
   localparam logic [31:0] USEC_HALF  = 32'd500000;
   localparam logic [79:0] INCR_SAT   = 80'(MASK32) * 80'(USEC_DIV);

   // Reciprocal of one million scaled by 2^51; the quotient estimate is
   // at most two low and is fixed up by compare and subtract
   localparam logic [31:0] USEC_RECIP    = 32'd2251799813;
   localparam int          USEC_RECIP_SH = 19;

   // Divider widths
   localparam int DIV_W = 33;
   localparam int DVD_W = 64;
   localparam int QUO_W = 32;
   localparam int CNT_W = 6;

   typedef struct packed {
      logic [31:0] process_noise;
      logic [31:0] measure_noise;
   } akf_cfg_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] count;
      logic [DIV_W-1:0] divisor;
      logic [DIV_W-1:0] rem_init;
      logic [DVD_W-1:0] dvd_init;
   } akf_div_req_type;

   typedef struct packed {
      logic             busy;
      logic [QUO_W-1:0] quot;
      logic [DIV_W-1:0] rem;
   } akf_div_rsp_type;

endpackage

### src/akf_csr.sv
module akf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [akf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [akf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [akf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output akf_pkg::akf_cfg_type             cfg
);
   import akf_pkg::*;

   logic [31:0] process_noise_ff, process_noise_in;
   logic [31:0] measure_noise_ff, measure_noise_in;
   logic        wr_en;
   logic        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   // Decode the write word
   always_comb begin
      process_noise_in = process_noise_ff;
      measure_noise_in = measure_noise_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_PROCESS_NOISE: process_noise_in = csr_pwdata;
            REG_MEASURE_NOISE: measure_noise_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         process_noise_ff <= PROCESS_NOISE_RST;
         measure_noise_ff <= MEASURE_NOISE_RST;
      end else begin
         process_noise_ff <= process_noise_in;
         measure_noise_ff <= measure_noise_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_sel)
         REG_PROCESS_NOISE: csr_prdata = process_noise_ff;
         REG_MEASURE_NOISE: csr_prdata = measure_noise_ff;
         default:           csr_prdata = process_noise_ff;
      endcase
   end

   assign cfg.process_noise = process_noise_ff;
   assign cfg.measure_noise = measure_noise_ff;

endmodule

### src/akf_divider.sv
module akf_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  akf_pkg::akf_div_req_type req,
   output akf_pkg::akf_div_rsp_type rsp
);
   import akf_pkg::*;

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [QUO_W-1:0] quot_ff, quot_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;
   logic             ge;

   // Shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge    = trial >= {1'b0, div_ff};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quot_in = quot_ff;
      priority if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.count;
         div_in  = req.divisor;
         rem_in  = req.rem_init;
         dvd_in  = req.dvd_init;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         dvd_in  = {dvd_ff[DVD_W-2:0], 1'b0};
         quot_in = {quot_ff[QUO_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

endmodule

### src/altitude_kalman_filter_unit.sv
// From input word accepted to rsp_tvalid: the first item after reset goes from
// ST_IDLE straight to ST_DONE; a rejected item passes ST_DIFF, ST_GMUL and ST_GCMP;
// an updated item also runs the FRAC_BITS + 1 steps of the bit-serial gain divider
// and the shared multiplier passes. One item at a time; ST_DONE stalls on a held result.
// Reset: synchronous, active high; clears the CSR registers to their defaults,
// variance to 3277, timestamp to zero and marks the estimate as not loaded.
module altitude_kalman_filter_unit #(
   parameter int FRAC_BITS = akf_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: range_measure [31:0], time_us [79:32]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [79:0]                      req_tdata,
   // tdata: altitude_estimate [31:0], variance_out [63:32]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [63:0]                      rsp_tdata,
   // tuser: status [1:0]
   output logic [akf_pkg::STATUS_W-1:0]     rsp_tuser,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [akf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [akf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [akf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import akf_pkg::*;

   localparam int          KW        = FRAC_BITS + 1;
   localparam int          GATE_SH   = 63 - FRAC_BITS;
   localparam logic [KW-1:0] K_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [63:0] HALF      = 64'(1) << (FRAC_BITS - 1);
   localparam logic [CNT_W-1:0] GAIN_STEPS = CNT_W'(FRAC_BITS + 1);

   typedef enum logic [20:0] {
      ST_IDLE  = 21'h000001,
      ST_DIFF  = 21'h000002,
      ST_GMUL  = 21'h000004,
      ST_GCMP  = 21'h000008,
      ST_QLO   = 21'h000010,
      ST_QHI   = 21'h000020,
      ST_QSUM  = 21'h000040,
      ST_RLO   = 21'h000080,
      ST_RHI   = 21'h000100,
      ST_RSUM  = 21'h000200,
      ST_RMUL  = 21'h000400,
      ST_RFIX  = 21'h000800,
      ST_PRED  = 21'h001000,
      ST_SSUM  = 21'h002000,
      ST_LOAD2 = 21'h004000,
      ST_DIV2  = 21'h008000,
      ST_GAIN  = 21'h010000,
      ST_CMUL  = 21'h020000,
      ST_CORR  = 21'h040000,
      ST_VUPD  = 21'h080000,
      ST_DONE  = 21'h100000
   } state_type;

   akf_cfg_type     cfg;
   akf_div_req_type div_req;
   akf_div_rsp_type div_rsp;

   state_type state_ff, state_in;
   logic              have_ff, have_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic [VAR_W-1:0]  variance_ff, variance_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [MEAS_W-1:0]   estimate_ff, estimate_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [MEAS_W-1:0]   meas_ff, meas_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [TIME_W-1:0]   dt_ff, dt_in;
   logic [MEAS_W-1:0]   mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [63:0]         prod_ff;
   logic [63:0]         acc_ff, acc_in;
   logic                sat_ff, sat_in;
   logic [31:0]         rlo_ff, rlo_in;
   logic [32:0]         incr_ff, incr_in;
   logic [VAR_W-1:0]    pp_ff, pp_in;
   logic [32:0]         s_ff, s_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [MEAS_W-1:0]   rsp_est_ff, rsp_est_in;
   logic [VAR_W-1:0]    rsp_var_ff, rsp_var_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic        req_fire;
   logic        out_free;
   logic        dt_big;
   logic        outlier;
   logic [79:0] qprod;
   logic [79:0] qround;
   logic [63:0] recip_sum;
   logic [63:0] usec_rem;
   logic [32:0] var_sum;
   logic [63:0] gain_num;
   logic [63:0] corr_full;
   logic [31:0] corr;
   logic [63:0] var_full;

   akf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   akf_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Shared multiplier operand select
   always_comb begin
      mul_a = mag_ff;
      mul_b = GATE_SCALE;
      unique case (state_ff)
         ST_QLO:  begin
            mul_a = cfg.process_noise;
            mul_b = 32'(dt_ff[23:0]);
         end
         ST_QHI:  begin
            mul_a = cfg.process_noise;
            mul_b = 32'(dt_ff[47:24]);
         end
         ST_RLO:  begin
            mul_a = acc_ff[31:0];
            mul_b = USEC_RECIP;
         end
         ST_RHI:  begin
            mul_a = acc_ff[63:32];
            mul_b = USEC_RECIP;
         end
         ST_RMUL: begin
            mul_a = incr_ff[31:0];
            mul_b = USEC_DIV;
         end
         ST_CMUL: begin
            mul_a = mag_ff;
            mul_b = 32'(k_ff);
         end
         ST_CORR: begin
            mul_a = pp_ff;
            mul_b = 32'(K_ONE - k_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

   // Datapath terms used by the sequencer
   assign dt_big    = ((64'(dt_ff) >> GATE_SH) != 64'd0);
   assign outlier   = !dt_big && (prod_ff > (64'(dt_ff) << FRAC_BITS));
   assign qprod     = 80'(acc_ff) + (80'(prod_ff) << 24);
   assign qround    = qprod + 80'(USEC_HALF);
   assign recip_sum = prod_ff + 64'(rlo_ff);
   assign usec_rem  = acc_ff - prod_ff;
   assign var_sum   = 33'(variance_ff) + incr_ff;
   assign gain_num  = (64'(pp_ff) << FRAC_BITS) + 64'(s_ff[32:1]);
   assign corr_full = (prod_ff + HALF) >> FRAC_BITS;
   assign corr      = (corr_full > 64'(mag_ff)) ? mag_ff : corr_full[31:0];
   assign var_full  = (prod_ff + HALF) >> FRAC_BITS;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      have_in       = have_ff;
      last_time_in  = last_time_ff;
      variance_in   = variance_ff;
      estimate_in   = estimate_ff;
      status_in     = status_ff;
      meas_in       = meas_ff;
      time_in       = time_ff;
      dt_in         = dt_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      acc_in        = acc_ff;
      sat_in        = sat_ff;
      rlo_in        = rlo_ff;
      incr_in       = incr_ff;
      pp_in         = pp_ff;
      s_in          = s_ff;
      k_in          = k_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_est_in    = rsp_est_ff;
      rsp_var_in    = rsp_var_ff;
      rsp_status_in = rsp_status_ff;
      div_req       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               meas_in = req_tdata[31:0];
               time_in = req_tdata[79:32];
               if (!have_ff) begin
                  estimate_in  = req_tdata[31:0];
                  last_time_in = req_tdata[79:32];
                  have_in      = 1'b1;
                  status_in    = STATUS_LOAD;
                  state_in     = ST_DONE;
               end else begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            dt_in    = (time_ff >= last_time_ff) ? (time_ff - last_time_ff) : '0;
            neg_in   = meas_ff < estimate_ff;
            mag_in   = (meas_ff < estimate_ff) ? (estimate_ff - meas_ff)
                                               : (meas_ff - estimate_ff);
            state_in = ST_GMUL;
         end
         ST_GMUL: state_in = ST_GCMP;
         ST_GCMP: begin
            if (outlier) begin
               status_in = STATUS_REJECT;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_QLO;
            end
         end
         ST_QLO: state_in = ST_QHI;
         ST_QHI: begin
            acc_in   = prod_ff;
            state_in = ST_QSUM;
         end
         ST_QSUM: begin
            // Hold the product plus half a million; when saturated the
            // quotient below is ignored
            sat_in   = qprod >= INCR_SAT;
            acc_in   = qround[63:0];
            state_in = ST_RLO;
         end
         ST_RLO: state_in = ST_RHI;
         ST_RHI: begin
            rlo_in   = prod_ff[63:32];
            state_in = ST_RSUM;
         end
         ST_RSUM: begin
            // Quotient estimate by reciprocal multiply
            incr_in  = 33'(recip_sum >> USEC_RECIP_SH);
            state_in = ST_RMUL;
         end
         ST_RMUL: state_in = ST_RFIX;
         ST_RFIX: begin
            // Bring the estimate up to the exact quotient
            priority if (usec_rem >= 64'(USEC_DIV2)) begin
               incr_in = incr_ff + 33'd2;
            end else if (usec_rem >= 64'(USEC_DIV)) begin
               incr_in = incr_ff + 33'd1;
            end
            state_in = ST_PRED;
         end
         ST_PRED: begin
            // Saturate the predicted variance
            if (sat_ff || (incr_ff >= 33'(MASK32)) || (var_sum > 33'(MASK32))) begin
               pp_in = MASK32;
            end else begin
               pp_in = var_sum[31:0];
            end
            state_in = ST_SSUM;
         end
         ST_SSUM: begin
            s_in     = 33'(pp_ff) + 33'(cfg.measure_noise);
            state_in = ST_LOAD2;
         end
         ST_LOAD2: begin
            if (s_ff == '0) begin
               k_in     = '0;
               state_in = ST_CMUL;
            end else begin
               div_req.start    = 1'b1;
               div_req.count    = GAIN_STEPS;
               div_req.divisor  = s_ff;
               div_req.rem_init = 33'(gain_num >> (FRAC_BITS + 1));
               div_req.dvd_init = gain_num << (64 - (FRAC_BITS + 1));
               state_in         = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (!div_rsp.busy) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            k_in     = (div_rsp.quot > 32'(K_ONE)) ? K_ONE : div_rsp.quot[KW-1:0];
            state_in = ST_CMUL;
         end
         ST_CMUL: state_in = ST_CORR;
         ST_CORR: begin
            // Move the estimate toward the measurement
            estimate_in = neg_ff ? (estimate_ff - corr) : (estimate_ff + corr);
            state_in    = ST_VUPD;
         end
         ST_VUPD: begin
            variance_in  = var_full[31:0];
            last_time_in = time_ff;
            status_in    = STATUS_UPDATE;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_est_in    = estimate_ff;
               rsp_var_in    = variance_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_ff      <= 1'b0;
         last_time_ff <= '0;
         variance_ff  <= VARIANCE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_ff      <= have_in;
         last_time_ff <= last_time_in;
         variance_ff  <= variance_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      estimate_ff   <= estimate_in;
      status_ff     <= status_in;
      meas_ff       <= meas_in;
      time_ff       <= time_in;
      dt_ff         <= dt_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      acc_ff        <= acc_in;
      sat_ff        <= sat_in;
      rlo_ff        <= rlo_in;
      incr_ff       <= incr_in;
      pp_ff         <= pp_in;
      s_ff          <= s_in;
      k_ff          <= k_in;
      rsp_est_ff    <= rsp_est_in;
      rsp_var_ff    <= rsp_var_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_var_ff, rsp_est_ff};
   assign rsp_tuser  = rsp_status_ff;

   // A rejected word leaves the filter state alone
   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GCMP && outlier) |=> $stable(variance_ff) && $stable(last_time_ff))
      else $error("rejected word changed filter state");

   // Never restart the divider mid-divide
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // Gain stays within one
   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMUL) |-> (k_ff <= K_ONE))
      else $error("gain above one");

   // Result register loads only from the finish state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word loaded outside finish state");

endmodule
